// ===== design/sps_pkg.sv =====
// Shared types, constants and a helper function for the spin profile sequencer.
package sps_pkg;

    localparam int RPM_BITS  = 13;
    localparam int REQ_BITS  = 14;
    localparam int TIME_BITS = 32;
    localparam int DZ_BITS   = 10;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [RPM_BITS-1:0] MAX_SPEED_RPM = 13'd6000;
    localparam logic [DZ_BITS-1:0]  DEADZONE_RESET = 10'd15;
    localparam logic [TIME_BITS-1:0] HOLD_MIN_MS = 32'd1;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TO_LOW    = 3'd1,
        PH_HOLD_LOW  = 3'd2,
        PH_TO_HIGH   = 3'd3,
        PH_HOLD_HIGH = 3'd4,
        PH_FINISH    = 3'd5,
        PH_STOP      = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_UP   = 2'd1,
        CMD_DOWN = 2'd2,
        CMD_HALT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_SET_TARGET = 2'd0,
        MODE_START      = 2'd1,
        MODE_TICK       = 2'd2,
        MODE_STOP       = 2'd3
    } t_mode;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_PROFILE_LOW  = 3'd0,
        CFG_PROFILE_HIGH = 3'd1,
        CFG_HOLD_LOW     = 3'd2,
        CFG_HOLD_HIGH    = 3'd3,
        CFG_DEADZONE     = 3'd4
    } t_cfg_addr;

    typedef struct packed {
        logic signed [REQ_BITS-1:0] profile_low_rpm;
        logic signed [REQ_BITS-1:0] profile_high_rpm;
        logic [TIME_BITS-1:0]       hold_low_ms;
        logic [TIME_BITS-1:0]       hold_high_ms;
        logic [DZ_BITS-1:0]         deadzone_rpm;
    } t_cfg;

    typedef struct packed {
        t_mode                      mode;
        logic signed [REQ_BITS-1:0] target_rpm;
        logic [RPM_BITS-1:0]        measured_rpm;
        logic                       motion_idle;
        logic [TIME_BITS-1:0]       now_ms;
    } t_in_item;

    typedef struct packed {
        t_cmd                command;
        logic [RPM_BITS-1:0] command_rpm;
        logic                send_finish;
        t_phase              sequence_state;
        logic [RPM_BITS-1:0] stored_target_rpm;
    } t_result;

    // clamp a signed request to 0..MAX_SPEED_RPM
    function automatic logic [RPM_BITS-1:0] clamp_speed(input logic signed [REQ_BITS-1:0] v);
        logic [RPM_BITS-1:0] mag;
        mag = v[RPM_BITS-1:0];
        if (v[REQ_BITS-1]) begin
            return '0;
        end else if (mag > MAX_SPEED_RPM) begin
            return MAX_SPEED_RPM;
        end else begin
            return mag;
        end
    endfunction

endpackage

// ===== design/sps_cfg.sv =====
// Configuration register file of the spin profile sequencer.
module sps_cfg import sps_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_PROFILE_LOW:  n_cfg.profile_low_rpm  = i_cfg_wdata[REQ_BITS-1:0];
                CFG_PROFILE_HIGH: n_cfg.profile_high_rpm = i_cfg_wdata[REQ_BITS-1:0];
                CFG_HOLD_LOW:     n_cfg.hold_low_ms      = i_cfg_wdata[TIME_BITS-1:0];
                CFG_HOLD_HIGH:    n_cfg.hold_high_ms     = i_cfg_wdata[TIME_BITS-1:0];
                CFG_DEADZONE:     n_cfg.deadzone_rpm     = i_cfg_wdata[DZ_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.profile_low_rpm  <= '0;
            r_cfg.profile_high_rpm <= '0;
            r_cfg.hold_low_ms      <= '0;
            r_cfg.hold_high_ms     <= '0;
            r_cfg.deadzone_rpm     <= DEADZONE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/sps_core.sv =====
// Profile state machine: sequencer state and the single-pass item evaluation.
module sps_core import sps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output t_result  o_result
);

    t_phase               r_phase, n_phase;
    logic [TIME_BITS-1:0] r_hold_start_ms, n_hold_start_ms;
    logic [RPM_BITS-1:0]  r_low_rpm, n_low_rpm;
    logic [RPM_BITS-1:0]  r_high_rpm, n_high_rpm;
    logic [TIME_BITS-1:0] r_hold_low_ms, n_hold_low_ms;
    logic [TIME_BITS-1:0] r_hold_high_ms, n_hold_high_ms;
    logic [RPM_BITS-1:0]  r_target_rpm, n_target_rpm;

    logic [RPM_BITS-1:0]  req_target;
    logic [RPM_BITS:0]    meas_plus_dz;
    logic [RPM_BITS:0]    target_plus_dz;
    logic                 below_dz;
    logic                 above_dz;
    logic [RPM_BITS-1:0]  cl_low;
    logic [RPM_BITS-1:0]  cl_high;
    logic                 swap;
    logic [TIME_BITS-1:0] elapsed;
    logic                 low_done;
    logic                 high_done;

    t_cmd                 cmd;
    logic [RPM_BITS-1:0]  cmd_rpm;
    logic                 finish;

    assign req_target     = clamp_speed(i_item.target_rpm);
    assign meas_plus_dz   = {1'b0, i_item.measured_rpm} + (RPM_BITS+1)'(i_cfg.deadzone_rpm);
    assign target_plus_dz = {1'b0, req_target} + (RPM_BITS+1)'(i_cfg.deadzone_rpm);
    // measured - target < -dz  and  measured - target > dz
    assign below_dz       = meas_plus_dz < {1'b0, req_target};
    assign above_dz       = {1'b0, i_item.measured_rpm} > target_plus_dz;

    assign cl_low  = clamp_speed(i_cfg.profile_low_rpm);
    assign cl_high = clamp_speed(i_cfg.profile_high_rpm);
    assign swap    = cl_low > cl_high;

    assign elapsed   = i_item.now_ms - r_hold_start_ms;
    assign low_done  = elapsed >= r_hold_low_ms;
    assign high_done = elapsed >= r_hold_high_ms;

    // next state
    always_comb begin
        n_phase = r_phase;
        case (i_item.mode)
            MODE_START: begin
                if (r_phase == PH_IDLE) begin
                    n_phase = PH_TO_LOW;
                end
            end
            MODE_TICK: begin
                unique case (r_phase)
                    PH_TO_LOW:    if (i_item.motion_idle) n_phase = PH_HOLD_LOW;
                    PH_HOLD_LOW:  if (low_done) n_phase = PH_TO_HIGH;
                    PH_TO_HIGH:   if (i_item.motion_idle) n_phase = PH_HOLD_HIGH;
                    PH_HOLD_HIGH: if (high_done) n_phase = PH_FINISH;
                    PH_FINISH, PH_STOP: if (i_item.motion_idle) n_phase = PH_IDLE;
                    default: ;
                endcase
            end
            MODE_STOP: begin
                if (r_phase != PH_IDLE) begin
                    n_phase = PH_STOP;
                end
            end
            default: ;
        endcase
    end

    // command outputs
    always_comb begin
        cmd     = CMD_NONE;
        cmd_rpm = '0;
        finish  = 1'b0;
        case (i_item.mode)
            MODE_SET_TARGET: begin
                if (r_phase == PH_IDLE && i_item.motion_idle) begin
                    if (below_dz) begin
                        cmd     = CMD_UP;
                        cmd_rpm = req_target;
                    end else if (above_dz) begin
                        cmd     = CMD_DOWN;
                        cmd_rpm = req_target;
                    end
                end
            end
            MODE_START: begin
                if (r_phase == PH_IDLE) begin
                    cmd     = CMD_UP;
                    cmd_rpm = swap ? cl_high : cl_low;
                end
            end
            MODE_TICK: begin
                unique case (r_phase)
                    PH_HOLD_LOW: begin
                        if (low_done) begin
                            cmd     = CMD_UP;
                            cmd_rpm = r_high_rpm;
                        end
                    end
                    PH_HOLD_HIGH: begin
                        if (high_done) cmd = CMD_DOWN;
                    end
                    PH_FINISH, PH_STOP: begin
                        if (i_item.motion_idle) begin
                            cmd    = CMD_HALT;
                            finish = (r_phase == PH_FINISH);
                        end
                    end
                    default: ;
                endcase
            end
            default: begin
                if (r_phase != PH_IDLE) cmd = CMD_DOWN;
            end
        endcase
    end

    // datapath state
    always_comb begin
        n_hold_start_ms = r_hold_start_ms;
        n_low_rpm       = r_low_rpm;
        n_high_rpm      = r_high_rpm;
        n_hold_low_ms   = r_hold_low_ms;
        n_hold_high_ms  = r_hold_high_ms;
        n_target_rpm    = r_target_rpm;
        if (r_phase == PH_IDLE && i_item.mode == MODE_SET_TARGET) begin
            n_target_rpm = req_target;
        end
        if (r_phase == PH_IDLE && i_item.mode == MODE_START) begin
            n_low_rpm      = swap ? cl_high : cl_low;
            n_high_rpm     = swap ? cl_low : cl_high;
            n_hold_low_ms  = (i_cfg.hold_low_ms == '0) ? HOLD_MIN_MS : i_cfg.hold_low_ms;
            n_hold_high_ms = (i_cfg.hold_high_ms == '0) ? HOLD_MIN_MS : i_cfg.hold_high_ms;
        end
        // entering a hold phase stamps the start time
        if (i_item.mode == MODE_TICK && i_item.motion_idle &&
            (r_phase == PH_TO_LOW || r_phase == PH_TO_HIGH)) begin
            n_hold_start_ms = i_item.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_target_rpm <= '0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_target_rpm <= n_target_rpm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hold_start_ms <= n_hold_start_ms;
            r_low_rpm       <= n_low_rpm;
            r_high_rpm      <= n_high_rpm;
            r_hold_low_ms   <= n_hold_low_ms;
            r_hold_high_ms  <= n_hold_high_ms;
        end
    end

    assign o_result.command           = cmd;
    assign o_result.command_rpm       = cmd_rpm;
    assign o_result.send_finish       = finish;
    assign o_result.sequence_state    = n_phase;
    assign o_result.stored_target_rpm = n_target_rpm;

endmodule

// ===== design/spin_profile_sequencer.sv =====
// Spin profile sequencer top level: stream ports, input and result registers.
// An item goes through the input register, then the result register, to the result port.
// Throughput: one item per cycle unless stalled; state updates in one evaluation stage.
// Back-pressure on the result side stalls the input register, which holds one item.
// Reset (synchronous, active low): phase idle, stored target 0, deadzone 15, other config
// registers 0, both pipeline registers empty.
module spin_profile_sequencer import sps_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [13:0] target_rpm, [26:14] measured_rpm, [27] motion_idle, [59:28] now_ms, [63:60] zero
    input  logic [63:0]              s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]               s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [1:0] command, [14:2] command_rpm, [15] send_finish, [18:16] sequence_state,
    // [31:19] stored_target_rpm
    output logic [31:0]              m_axis_tdata,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    t_cfg     cfg;
    t_in_item in_item;
    t_result  result;

    logic     r_in_valid;
    t_in_item r_in_item;
    logic     r_out_valid;
    t_result  r_out;
    logic     advance;

    assign in_item.mode         = t_mode'(s_axis_tuser);
    assign in_item.target_rpm   = s_axis_tdata[13:0];
    assign in_item.measured_rpm = s_axis_tdata[26:14];
    assign in_item.motion_idle  = s_axis_tdata[27];
    assign in_item.now_ms       = s_axis_tdata[59:28];

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_valid <= s_axis_tvalid;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) r_in_item <= in_item;
        if (advance) r_out <= result;
    end

    sps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    sps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.stored_target_rpm, r_out.sequence_state,
                            r_out.send_finish, r_out.command_rpm, r_out.command};

endmodule
